@@ hdl/clx_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// clx_pkg
// Shared types, codes and character helpers for the C-like source lexer.
// ----------------------------------------------------------------------------
package clx_pkg;

    localparam int unsigned QDepth = 4;
    localparam int unsigned QAw    = $clog2(QDepth);

    typedef enum logic [2:0] {
        K_IDENT  = 3'd0,
        K_NUMBER = 3'd1,
        K_STRING = 3'd2,
        K_OP     = 3'd3,
        K_END    = 3'd4,
        K_ERROR  = 3'd5
    } t_kind;

    typedef enum logic [3:0] {
        M_IDLE       = 4'd0,
        M_IDENT      = 4'd1,
        M_NUMBER     = 4'd2,
        M_STRING     = 4'd3,
        M_ESCAPE     = 4'd4,
        M_SLASH      = 4'd5,
        M_BLOCK      = 4'd6,
        M_BLOCK_STAR = 4'd7,
        M_LINE       = 4'd8,
        M_ERROR      = 4'd9
    } t_mode;

    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_TAB    = 8'h09;
    localparam logic [7:0] C_CR     = 8'h0d;
    localparam logic [7:0] C_LF     = 8'h0a;
    localparam logic [7:0] C_BS     = 8'h08;
    localparam logic [7:0] C_FF     = 8'h0c;
    localparam logic [7:0] C_UNDER  = 8'h5f;
    localparam logic [7:0] C_PLUS   = 8'h2b;
    localparam logic [7:0] C_MINUS  = 8'h2d;
    localparam logic [7:0] C_DOT    = 8'h2e;
    localparam logic [7:0] C_QUOTE  = 8'h22;
    localparam logic [7:0] C_SLASH  = 8'h2f;
    localparam logic [7:0] C_STAR   = 8'h2a;
    localparam logic [7:0] C_BSLASH = 8'h5c;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        t_kind      kind;
        logic       start;
    } t_res;

    // One queue entry: the results of one input transaction (one or two).
    typedef struct packed {
        logic two;
        t_res res0;
        t_res res1;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef struct packed {
        logic  emit;
        t_res  res;
        t_mode mode;
    } t_idle;

    typedef struct packed {
        logic       ok;
        logic [7:0] data;
    } t_esc;

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic t_res mk_res(input logic [7:0] d, input logic h,
                                    input t_kind k, input logic s);
        t_res r;
        r.data  = d;
        r.has   = h;
        r.kind  = k;
        r.start = s;
        return r;
    endfunction

    function automatic t_idle lex_idle(input logic [7:0] c);
        t_idle o;
        o.emit = 1'b0;
        o.res  = mk_res(8'h00, 1'b0, K_OP, 1'b0);
        o.mode = M_IDLE;
        if (c == C_SPACE || c == C_TAB || c == C_CR || c == C_LF) begin
            o.mode = M_IDLE;
        end else if (c == C_UNDER || is_alpha(c)) begin
            o.emit = 1'b1;
            o.res  = mk_res(c, 1'b1, K_IDENT, 1'b1);
            o.mode = M_IDENT;
        end else if (c == C_PLUS || c == C_MINUS || is_digit(c)) begin
            o.emit = 1'b1;
            o.res  = mk_res(c, 1'b1, K_NUMBER, 1'b1);
            o.mode = M_NUMBER;
        end else if (c == C_QUOTE) begin
            o.emit = 1'b1;
            o.res  = mk_res(8'h00, 1'b0, K_STRING, 1'b1);
            o.mode = M_STRING;
        end else if (c == C_SLASH) begin
            o.mode = M_SLASH;
        end else begin
            o.emit = 1'b1;
            o.res  = mk_res(c, 1'b1, K_OP, 1'b1);
            o.mode = M_IDLE;
        end
        return o;
    endfunction

    function automatic t_esc decode_esc(input logic [7:0] c);
        t_esc e;
        e.ok   = 1'b1;
        e.data = c;
        if (c == C_BSLASH || c == C_SLASH || c == C_QUOTE) begin
            e.data = c;
        end else if (c == 8'h62) begin
            e.data = C_BS;
        end else if (c == 8'h66) begin
            e.data = C_FF;
        end else if (c == 8'h6e) begin
            e.data = C_LF;
        end else if (c == 8'h72) begin
            e.data = C_CR;
        end else if (c == 8'h74) begin
            e.data = C_TAB;
        end else begin
            e.ok   = 1'b0;
            e.data = 8'h00;
        end
        return e;
    endfunction

endpackage
`default_nettype wire

@@ hdl/clx_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// clx_front
// Accepts source bytes, runs the lexer mode machine and pushes the results
// (one or two) of each transaction that yields any into the queue.
// ----------------------------------------------------------------------------
module clx_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_eoi,
    input  wire clx_pkg::t_qstat i_qstat,
    output logic                 o_stall,
    output logic                 o_push,
    output clx_pkg::t_entry      o_entry
);
    import clx_pkg::*;

    t_mode r_mode, n_mode;
    logic  r_dot, n_dot;
    logic  accept;
    logic  emit0, emit1;
    t_res  res0, res1;
    t_idle idl;
    t_esc  esc;

    assign o_stall = i_qstat.full;
    assign accept  = i_valid && !i_qstat.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_dot  <= 1'b0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_dot  <= n_dot;
        end
    end

    always_comb begin
        idl    = lex_idle(i_byte);
        esc    = decode_esc(i_byte);
        n_mode = r_mode;
        n_dot  = r_dot;
        emit0  = 1'b0;
        emit1  = 1'b0;
        res0   = mk_res(8'h00, 1'b0, K_OP, 1'b0);
        res1   = mk_res(8'h00, 1'b0, K_OP, 1'b0);
        if (i_eoi) begin
            n_mode = M_IDLE;
            n_dot  = 1'b0;
            emit0  = 1'b1;
            if (r_mode == M_SLASH) begin
                res0  = mk_res(C_SLASH, 1'b1, K_OP, 1'b1);
                emit1 = 1'b1;
                res1  = mk_res(8'h00, 1'b0, K_END, 1'b1);
            end else if (r_mode == M_STRING || r_mode == M_ESCAPE) begin
                res0  = mk_res(8'h00, 1'b0, K_ERROR, 1'b1);
                emit1 = 1'b1;
                res1  = mk_res(8'h00, 1'b0, K_END, 1'b1);
            end else begin
                res0  = mk_res(8'h00, 1'b0, K_END, 1'b1);
            end
        end else begin
            unique case (r_mode)
                M_IDENT: begin
                    if (i_byte == C_UNDER || is_alpha(i_byte) || is_digit(i_byte)) begin
                        emit0 = 1'b1;
                        res0  = mk_res(i_byte, 1'b1, K_IDENT, 1'b0);
                    end else begin
                        emit0  = idl.emit;
                        res0   = idl.res;
                        n_mode = idl.mode;
                        n_dot  = 1'b0;
                    end
                end
                M_NUMBER: begin
                    if (i_byte == C_DOT) begin
                        emit0 = 1'b1;
                        if (r_dot) begin
                            res0   = mk_res(8'h00, 1'b0, K_ERROR, 1'b1);
                            n_mode = M_ERROR;
                            n_dot  = 1'b0;
                        end else begin
                            res0  = mk_res(i_byte, 1'b1, K_NUMBER, 1'b0);
                            n_dot = 1'b1;
                        end
                    end else if (is_digit(i_byte)) begin
                        emit0 = 1'b1;
                        res0  = mk_res(i_byte, 1'b1, K_NUMBER, 1'b0);
                    end else begin
                        emit0  = idl.emit;
                        res0   = idl.res;
                        n_mode = idl.mode;
                        n_dot  = 1'b0;
                    end
                end
                M_STRING: begin
                    if (i_byte == C_BSLASH) begin
                        n_mode = M_ESCAPE;
                    end else if (i_byte == C_QUOTE) begin
                        n_mode = M_IDLE;
                    end else begin
                        emit0 = 1'b1;
                        res0  = mk_res(i_byte, 1'b1, K_STRING, 1'b0);
                    end
                end
                M_ESCAPE: begin
                    emit0 = 1'b1;
                    if (esc.ok) begin
                        res0   = mk_res(esc.data, 1'b1, K_STRING, 1'b0);
                        n_mode = M_STRING;
                    end else begin
                        res0   = mk_res(8'h00, 1'b0, K_ERROR, 1'b1);
                        n_mode = M_ERROR;
                        n_dot  = 1'b0;
                    end
                end
                M_SLASH: begin
                    if (i_byte == C_STAR) begin
                        n_mode = M_BLOCK;
                    end else if (i_byte == C_SLASH) begin
                        n_mode = M_LINE;
                    end else begin
                        emit0  = 1'b1;
                        res0   = mk_res(C_SLASH, 1'b1, K_OP, 1'b1);
                        emit1  = idl.emit;
                        res1   = idl.res;
                        n_mode = idl.mode;
                        n_dot  = 1'b0;
                    end
                end
                M_BLOCK: begin
                    if (i_byte == C_STAR) begin
                        n_mode = M_BLOCK_STAR;
                    end
                end
                M_BLOCK_STAR: begin
                    if (i_byte == C_SLASH) begin
                        n_mode = M_IDLE;
                    end else if (i_byte != C_STAR) begin
                        n_mode = M_BLOCK;
                    end
                end
                M_LINE: begin
                    if (i_byte == C_LF) begin
                        n_mode = M_IDLE;
                    end
                end
                M_ERROR: begin
                    n_mode = M_ERROR;
                end
                default: begin
                    emit0  = idl.emit;
                    res0   = idl.res;
                    n_mode = idl.mode;
                    n_dot  = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_push       = accept && (emit0 || emit1);
        o_entry.two  = emit0 && emit1;
        o_entry.res0 = emit0 ? res0 : res1;
        o_entry.res1 = res1;
    end

endmodule
`default_nettype wire

@@ hdl/clx_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// clx_queue
// Small FIFO of result groups between the lexer front and the output stage.
// ----------------------------------------------------------------------------
module clx_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire clx_pkg::t_entry i_entry,
    input  wire logic            i_pop,
    output clx_pkg::t_entry      o_head,
    output clx_pkg::t_qstat      o_qstat
);
    import clx_pkg::*;

    t_entry              r_mem [QDepth];
    logic [QAw-1:0]      r_wr, r_rd;
    logic [QAw:0]        r_cnt;
    logic                do_push, do_pop;

    assign o_qstat.full  = (r_cnt == (QAw+1)'(QDepth));
    assign o_qstat.empty = (r_cnt == '0);
    assign do_push       = i_push && !o_qstat.full;
    assign do_pop        = i_pop && !o_qstat.empty;
    assign o_head        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/clx_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// clx_back
// Output stage: splits each queued group into single results, marks the
// last one of the group and holds it in the output register.
// ----------------------------------------------------------------------------
module clx_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire clx_pkg::t_entry i_head,
    input  wire clx_pkg::t_qstat i_qstat,
    input  wire logic            i_stall,
    output logic                 o_pop,
    output logic                 o_valid,
    output clx_pkg::t_res        o_res,
    output logic                 o_last
);
    import clx_pkg::*;

    logic r_valid;
    logic r_sel, n_sel;
    t_res r_res, n_res;
    logic r_last, n_last;
    logic load;

    assign load    = (!r_valid || !i_stall) && !i_qstat.empty;
    assign o_valid = r_valid;
    assign o_res   = r_res;
    assign o_last  = r_last;

    always_comb begin
        if (i_head.two && !r_sel) begin
            n_res  = i_head.res0;
            n_last = 1'b0;
            n_sel  = 1'b1;
            o_pop  = 1'b0;
        end else begin
            n_res  = r_sel ? i_head.res1 : i_head.res0;
            n_last = 1'b1;
            n_sel  = 1'b0;
            o_pop  = load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_sel   <= n_sel;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res  <= n_res;
            r_last <= n_last;
        end
    end

endmodule
`default_nettype wire

@@ hdl/c_like_source_lexer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// c_like_source_lexer
// Streaming lexer for C-like source text, one source byte per transaction.
//
// Input channel: i_in_valid / o_in_stall carry i_in_byte and i_end_of_input.
// A transaction with i_end_of_input high ends the source and yields an end
// marker; the lexer then starts over for a new source.
// Output channel: o_out_valid / i_out_stall carry one result per transaction:
// o_out_byte, o_has_byte, o_token_kind, o_token_start, o_last_of_run.
// Each input transaction yields zero, one or two results, in order.
// A result is written into the queue and then loaded into the output register.
// Throughput: one input byte per cycle while o_in_stall is low; a byte that
// yields two results hands them to the output one after the other. A
// four-entry queue between the lexer and the output register absorbs this
// and output stalls; o_in_stall rises only when that queue is full.
// Reset (synchronous, active low) returns the lexer to between tokens,
// empties the queue and drops any result not yet taken.
// ----------------------------------------------------------------------------
module c_like_source_lexer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_end_of_input,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_has_byte,
    output logic [2:0]      o_token_kind,
    output logic            o_token_start,
    output logic            o_last_of_run
);
    import clx_pkg::*;

    t_qstat qstat;
    t_entry push_entry, head;
    logic   push, pop;
    t_res   res;

    clx_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_byte  (i_in_byte),
        .i_eoi   (i_end_of_input),
        .i_qstat (qstat),
        .o_stall (o_in_stall),
        .o_push  (push),
        .o_entry (push_entry)
    );

    clx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    clx_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (qstat),
        .i_stall (i_out_stall),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .o_res   (res),
        .o_last  (o_last_of_run)
    );

    assign o_out_byte    = res.data;
    assign o_has_byte    = res.has;
    assign o_token_kind  = 3'(res.kind);
    assign o_token_start = res.start;

endmodule
`default_nettype wire
